[sv/spf_pkg.sv]
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types and constants for the servo instruction packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int MAX_WRITE_BYTES = 4;
    localparam int DATA_FIELDS     = 4;
    localparam int WRITE_LIMIT_RAW = (MAX_WRITE_BYTES < DATA_FIELDS) ? MAX_WRITE_BYTES
                                                                      : DATA_FIELDS;
    localparam int WRITE_LIMIT     = (WRITE_LIMIT_RAW < 1) ? 1 : WRITE_LIMIT_RAW;
    localparam int DATA_SEL_W      = $clog2(DATA_FIELDS);

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SYNC_BYTE      = 8'hFF;
    localparam logic [7:0] READ_LEN_BYTE  = 8'h04;
    localparam logic [7:0] INSTR_READ     = 8'h02;
    localparam logic [7:0] INSTR_WRITE    = 8'h03;
    localparam logic [7:0] SERVO_ID_RESET = 8'h01;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // byte positions within a packet
    localparam logic [3:0] POS_SYNC0 = 4'd0;
    localparam logic [3:0] POS_SYNC1 = 4'd1;
    localparam logic [3:0] POS_ID    = 4'd2;
    localparam logic [3:0] POS_LEN   = 4'd3;
    localparam logic [3:0] POS_INSTR = 4'd4;
    localparam logic [3:0] POS_START = 4'd5;
    localparam logic [3:0] POS_DATA  = 4'd6;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t                       servo_id;
        byte_t                       len_byte;
        byte_t                       instr;
        byte_t                       start;
        logic [DATA_FIELDS-1:0][7:0] payload;
        logic [2:0]                  count;
        byte_t                       checksum;
    } desc_t;

endpackage

[sv/spf_req_if.sv]
// ----------------------------------------------------------------------------
// spf_req_if
// Request channel: one read or write request per transfer.
// ----------------------------------------------------------------------------
interface spf_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  start_address;
    logic [7:0]  read_length;
    logic [2:0]  data_count;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;

    modport source (
        output valid, opcode, start_address, read_length, data_count,
               data_0, data_1, data_2, data_3,
        input  ready
    );

    modport sink (
        input  valid, opcode, start_address, read_length, data_count,
               data_0, data_1, data_2, data_3,
        output ready
    );
endinterface

[sv/spf_byte_if.sv]
// ----------------------------------------------------------------------------
// spf_byte_if
// Packet byte channel: one packet byte per transfer.
// ----------------------------------------------------------------------------
interface spf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (
        output valid, packet_byte, last_byte,
        input  ready
    );

    modport sink (
        input  valid, packet_byte, last_byte,
        output ready
    );
endinterface

[sv/spf_front.sv]
// ----------------------------------------------------------------------------
// spf_front
// Accepts requests, classifies read/write, and builds a packet descriptor
// with length, instruction, data count and checksum.
// ----------------------------------------------------------------------------
module spf_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_wdata,
    spf_req_if.sink        req,
    output logic           push_valid,
    input  logic           push_ready,
    output spf_pkg::desc_t push_data
);

    spf_pkg::byte_t servo_id_reg;
    logic [2:0]     wr_count;
    spf_pkg::byte_t sum;
    spf_pkg::desc_t desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_id_reg <= spf_pkg::SERVO_ID_RESET;
        end
        else if (cfg_we)
        begin
            servo_id_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (req.data_count == 3'd0)
        begin
            wr_count = 3'd1;
        end
        else if (req.data_count > 3'(spf_pkg::WRITE_LIMIT))
        begin
            wr_count = 3'(spf_pkg::WRITE_LIMIT);
        end
        else
        begin
            wr_count = req.data_count;
        end
    end

    always_comb
    begin
        desc          = '0;
        desc.servo_id = servo_id_reg;
        desc.start    = req.start_address;
        if (req.opcode == spf_pkg::OP_READ)
        begin
            desc.len_byte   = spf_pkg::READ_LEN_BYTE;
            desc.instr      = spf_pkg::INSTR_READ;
            desc.payload[0] = req.read_length;
            desc.count      = 3'd1;
        end
        else
        begin
            desc.len_byte   = 8'd3 + {5'd0, wr_count};
            desc.instr      = spf_pkg::INSTR_WRITE;
            desc.payload[0] = req.data_0;
            desc.payload[1] = req.data_1;
            desc.payload[2] = req.data_2;
            desc.payload[3] = req.data_3;
            desc.count      = wr_count;
        end

        sum = desc.servo_id + desc.len_byte + desc.instr + desc.start;
        for (int i = 0; i < spf_pkg::DATA_FIELDS; i++)
        begin
            if (3'(i) < desc.count)
            begin
                sum = sum + desc.payload[i];
            end
        end
        desc.checksum = ~sum;
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;
    assign push_data  = desc;

endmodule

[sv/spf_queue.sv]
// ----------------------------------------------------------------------------
// spf_queue
// Short descriptor queue between the request front and the byte sequencer.
// ----------------------------------------------------------------------------
module spf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  spf_pkg::desc_t push_data,
    output logic           pop_valid,
    input  logic           pop,
    output spf_pkg::desc_t pop_data
);

    spf_pkg::desc_t                   entry_reg [spf_pkg::QUEUE_DEPTH];
    logic [spf_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [spf_pkg::QUEUE_PTR_W-1:0]  wr_ptr_next;
    logic [spf_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [spf_pkg::QUEUE_PTR_W-1:0]  rd_ptr_next;
    logic [spf_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [spf_pkg::QUEUE_CNT_W-1:0]  count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != spf_pkg::QUEUE_CNT_W'(spf_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == spf_pkg::QUEUE_PTR_W'(spf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == spf_pkg::QUEUE_PTR_W'(spf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/spf_back.sv]
// ----------------------------------------------------------------------------
// spf_back
// Byte sequencer: walks the head descriptor one packet byte per cycle, unless
// stalled by pkt.ready low, into a registered output stage.
// ----------------------------------------------------------------------------
module spf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  spf_pkg::desc_t q_data,
    output logic           q_pop,
    spf_byte_if.source     pkt
);

    logic [3:0]                     idx_reg;
    logic [3:0]                     idx_next;
    logic                           pkt_valid_reg;
    logic                           pkt_valid_next;
    spf_pkg::byte_t                 pkt_byte_reg;
    logic                           pkt_last_reg;
    logic                           advance;
    logic                           fire;
    logic                           at_last;
    logic [3:0]                     last_pos;
    logic [spf_pkg::DATA_SEL_W-1:0] data_sel;
    spf_pkg::byte_t                 cur_byte;

    assign advance  = !pkt_valid_reg || pkt.ready;
    assign fire     = advance && q_valid;
    assign last_pos = spf_pkg::POS_DATA + {1'b0, q_data.count};
    assign at_last  = (idx_reg == last_pos);
    assign data_sel = spf_pkg::DATA_SEL_W'(idx_reg - spf_pkg::POS_DATA);
    assign q_pop    = fire && at_last;

    always_comb
    begin
        case (idx_reg)
            spf_pkg::POS_SYNC0: cur_byte = spf_pkg::SYNC_BYTE;
            spf_pkg::POS_SYNC1: cur_byte = spf_pkg::SYNC_BYTE;
            spf_pkg::POS_ID:    cur_byte = q_data.servo_id;
            spf_pkg::POS_LEN:   cur_byte = q_data.len_byte;
            spf_pkg::POS_INSTR: cur_byte = q_data.instr;
            spf_pkg::POS_START: cur_byte = q_data.start;
            default:            cur_byte = at_last ? q_data.checksum
                                                   : q_data.payload[data_sel];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        pkt_valid_next = pkt_valid_reg;
        if (fire)
        begin
            idx_next       = at_last ? spf_pkg::POS_SYNC0 : idx_reg + 4'd1;
            pkt_valid_next = 1'b1;
        end
        else if (advance)
        begin
            pkt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= spf_pkg::POS_SYNC0;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pkt_byte_reg <= cur_byte;
            pkt_last_reg <= at_last;
        end
    end

    assign pkt.valid       = pkt_valid_reg;
    assign pkt.packet_byte = pkt_byte_reg;
    assign pkt.last_byte   = pkt_last_reg;

endmodule

[sv/servo_instruction_packet_framer_top.sv]
// ----------------------------------------------------------------------------
// servo_instruction_packet_framer_top
// Builds serial servo instruction packets from read/write requests.
// ----------------------------------------------------------------------------
// A read request yields the 8-byte packet FF FF id 04 02 start length chk, a
// write request FF FF id 3+n 03 start data.. chk (n = 1..4, 0 taken as 1),
// one byte per transfer with last_byte set on the checksum. The byte
// sequencer emits one byte per cycle unless stalled by pkt.ready low, and
// packets follow each other with no gap. A two-entry descriptor queue lets
// requests be accepted while the previous packet is still going out.
// servo_id resets to 1 and is sampled when a request is accepted.
module servo_instruction_packet_framer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    spf_req_if.sink    req,
    spf_byte_if.source pkt
);

    logic           push_valid;
    logic           push_ready;
    spf_pkg::desc_t push_data;
    logic           q_valid;
    logic           q_pop;
    spf_pkg::desc_t q_data;

    spf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    spf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    spf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pkt     (pkt)
    );

endmodule

[sv/spf_checker.sv]
// ----------------------------------------------------------------------------
// spf_checker
// Port-level checks on packet framing, bound to the framer top level.
// ----------------------------------------------------------------------------
module spf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       pkt_valid,
    input logic       pkt_ready,
    input logic [7:0] pkt_byte,
    input logic       pkt_last
);

    logic [3:0] pos_reg;
    logic [2:0] pending_reg;
    logic       req_xfer;
    logic       pkt_xfer;
    logic       pkt_done;

    assign req_xfer = req_valid && req_ready;
    assign pkt_xfer = pkt_valid && pkt_ready;
    assign pkt_done = pkt_xfer && pkt_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (pkt_done)
            begin
                pos_reg <= '0;
            end
            else if (pkt_xfer)
            begin
                pos_reg <= pos_reg + 4'd1;
            end
            if (req_xfer && !pkt_done)
            begin
                pending_reg <= pending_reg + 3'd1;
            end
            else if (pkt_done && !req_xfer)
            begin
                pending_reg <= pending_reg - 3'd1;
            end
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt_byte) && $stable(pkt_last))
        else $error("packet byte changed while stalled");

    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pos_reg <= spf_pkg::POS_SYNC1 |->
            pkt_byte == spf_pkg::SYNC_BYTE && !pkt_last)
        else $error("packet does not open with two sync bytes");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_last |-> pos_reg >= 4'd7 && pos_reg <= 4'd10)
        else $error("checksum byte at wrong position");

    a_instr: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pos_reg == spf_pkg::POS_INSTR |->
            pkt_byte == spf_pkg::INSTR_READ || pkt_byte == spf_pkg::INSTR_WRITE)
        else $error("bad instruction byte");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid |-> pending_reg != 3'd0)
        else $error("packet byte without an accepted request");

endmodule

bind servo_instruction_packet_framer_top spf_checker u_spf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .pkt_valid (pkt.valid),
    .pkt_ready (pkt.ready),
    .pkt_byte  (pkt.packet_byte),
    .pkt_last  (pkt.last_byte)
);
